[design/tnuv_pkg.sv]
// Shared types and constants for the topic name UTF-8 validator.
// No dependencies; imported by tnuv_name_check and topic_name_utf8_validator.
`default_nettype none

package tnuv_pkg;

   // Widths of the stream fields
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned COUNT_W  = 7;
   localparam int unsigned REASON_W = 3;
   localparam int unsigned RULE_W   = 3;

   // Length counter saturates here
   localparam logic [COUNT_W-1:0] COUNT_MAX        = 7'd127;
   localparam logic [COUNT_W-1:0] MAX_LENGTH_RESET = 7'd64;

   // Verdict reason codes
   localparam logic [REASON_W-1:0] REASON_OK        = 3'd0;
   localparam logic [REASON_W-1:0] REASON_EMPTY     = 3'd1;
   localparam logic [REASON_W-1:0] REASON_TOO_LONG  = 3'd2;
   localparam logic [REASON_W-1:0] REASON_DOT_NAME  = 3'd3;
   localparam logic [REASON_W-1:0] REASON_FORBIDDEN = 3'd4;
   localparam logic [REASON_W-1:0] REASON_BAD_UTF8  = 3'd5;

   // Range rule applied to the byte after a special lead byte
   localparam logic [RULE_W-1:0] RULE_NONE     = 3'd0;
   localparam logic [RULE_W-1:0] RULE_GE_A0    = 3'd1;  // after E0
   localparam logic [RULE_W-1:0] RULE_LT_A0    = 3'd2;  // after ED
   localparam logic [RULE_W-1:0] RULE_GE_90    = 3'd3;  // after F0
   localparam logic [RULE_W-1:0] RULE_LT_90    = 3'd4;  // after F4

   // Per-name scan state
   typedef struct packed {
      logic [COUNT_W-1:0] byte_count;
      logic [1:0]         cont_left;
      logic [RULE_W-1:0]  rule;
      logic               forbidden_seen;
      logic               utf8_err_seen;
      logic               all_dots;
   } name_state_type;

   localparam name_state_type NAME_STATE_CLEAR = '{
      byte_count:     '0,
      cont_left:      2'd0,
      rule:           RULE_NONE,
      forbidden_seen: 1'b0,
      utf8_err_seen:  1'b0,
      all_dots:       1'b1
   };

endpackage

`default_nettype wire

[design/tnuv_name_check.sv]
// Combinational scan step: folds one byte into the name state and forms the verdict.
// Depends on tnuv_pkg.
`default_nettype none

module tnuv_name_check (
   input  wire tnuv_pkg::name_state_type    cur_state,
   input  wire logic [tnuv_pkg::BYTE_W-1:0]  byte_in,
   input  wire logic                         no_byte,
   input  wire logic [tnuv_pkg::COUNT_W-1:0] max_length,
   output tnuv_pkg::name_state_type         nxt_state,
   output logic [tnuv_pkg::REASON_W-1:0]    fail_reason
);
   import tnuv_pkg::*;

   logic forbidden_byte;
   logic cont_bad;

   // Control bytes and path / wildcard punctuation
   always_comb begin
      forbidden_byte = (byte_in < 8'h20) || (byte_in == 8'h2F) || (byte_in == 8'h5C) ||
                       (byte_in == 8'h3A) || (byte_in == 8'h2A) || (byte_in == 8'h3F) ||
                       (byte_in == 8'h22) || (byte_in == 8'h3C) || (byte_in == 8'h3E) ||
                       (byte_in == 8'h7C);
   end

   // Continuation byte check including the second-byte range rule
   always_comb begin
      cont_bad = (byte_in & 8'hC0) != 8'h80;
      case (cur_state.rule)
         RULE_GE_A0: cont_bad = cont_bad || (byte_in <  8'hA0);
         RULE_LT_A0: cont_bad = cont_bad || (byte_in >= 8'hA0);
         RULE_GE_90: cont_bad = cont_bad || (byte_in <  8'h90);
         RULE_LT_90: cont_bad = cont_bad || (byte_in >= 8'h90);
         default:    cont_bad = cont_bad;
      endcase
   end

   // State update
   always_comb begin
      nxt_state = cur_state;
      if (!no_byte) begin
         if (cur_state.byte_count != COUNT_MAX) begin
            nxt_state.byte_count = cur_state.byte_count + 7'd1;
         end
         if (byte_in != 8'h2E) begin
            nxt_state.all_dots = 1'b0;
         end
         if (forbidden_byte) begin
            nxt_state.forbidden_seen = 1'b1;
         end
         if (cur_state.cont_left != 2'd0) begin
            if (cont_bad) begin
               nxt_state.utf8_err_seen = 1'b1;
               nxt_state.cont_left     = 2'd0;
               nxt_state.rule          = RULE_NONE;
            end else begin
               nxt_state.cont_left = cur_state.cont_left - 2'd1;
               nxt_state.rule      = RULE_NONE;
            end
         end else if (byte_in < 8'h80) begin
            nxt_state.rule = cur_state.rule;
         end else if (byte_in >= 8'hC2 && byte_in <= 8'hDF) begin
            nxt_state.cont_left = 2'd1;
            nxt_state.rule      = RULE_NONE;
         end else if (byte_in >= 8'hE0 && byte_in <= 8'hEF) begin
            nxt_state.cont_left = 2'd2;
            nxt_state.rule      = (byte_in == 8'hE0) ? RULE_GE_A0 :
                                  (byte_in == 8'hED) ? RULE_LT_A0 : RULE_NONE;
         end else if (byte_in >= 8'hF0 && byte_in <= 8'hF4) begin
            nxt_state.cont_left = 2'd3;
            nxt_state.rule      = (byte_in == 8'hF0) ? RULE_GE_90 :
                                  (byte_in == 8'hF4) ? RULE_LT_90 : RULE_NONE;
         end else begin
            nxt_state.utf8_err_seen = 1'b1;
            nxt_state.cont_left     = 2'd0;
            nxt_state.rule          = RULE_NONE;
         end
      end
   end

   // Verdict, first fault in priority order wins
   always_comb begin
      if (nxt_state.byte_count == '0) begin
         fail_reason = REASON_EMPTY;
      end else if (nxt_state.byte_count > max_length) begin
         fail_reason = REASON_TOO_LONG;
      end else if (nxt_state.all_dots &&
                   (nxt_state.byte_count == 7'd1 || nxt_state.byte_count == 7'd2)) begin
         fail_reason = REASON_DOT_NAME;
      end else if (nxt_state.forbidden_seen) begin
         fail_reason = REASON_FORBIDDEN;
      end else if (nxt_state.utf8_err_seen || nxt_state.cont_left != 2'd0) begin
         fail_reason = REASON_BAD_UTF8;
      end else begin
         fail_reason = REASON_OK;
      end
   end

endmodule

`default_nettype wire

[design/topic_name_utf8_validator.sv]
// Topic name validator top level: input register, scan step, result register.
// Depends on tnuv_pkg and tnuv_name_check.
//
// Usage:
//   req_* carries one name byte per transfer; req_tlast marks the final item
//   of a name, req_tuser marks an item that carries no byte (with req_tlast it
//   ends the name, possibly empty). rsp_* gives one verdict per name: name_ok
//   and a reason code. csr_* writes max_length (reset 64); write it only
//   while no name is in flight.
// Timing:
//   One byte per cycle sustained while the verdict stream is not stalled.
//   A byte is held in the input register; the scan step folds it into the
//   name state as it leaves, and the verdict of a name is written to the
//   result register as its final item leaves the input register.
// Reset: synchronous, clears the name state and both stages, and sets
//   max_length back to 64.
// Stall: while rsp_tready is low the verdict holds in the result register;
//   bytes that end no name keep flowing, and a following name end waits in
//   the input register, which then stops req_tready.
`default_nettype none

module topic_name_utf8_validator (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] byte_in
   input  wire logic        req_tlast,   // last_byte
   input  wire logic        req_tuser,   // no_byte
   // Verdict stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [0] name_ok, [3:1] fail_reason, [7:4] zero
   // Configuration write
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [6:0]  csr_data     // max_length
);
   import tnuv_pkg::*;

   // Input register
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff,  in_byte_in;
   logic              in_last_ff,  in_last_in;
   logic              in_none_ff,  in_none_in;

   // Name state and config
   name_state_type     state_ff, state_in;
   logic [COUNT_W-1:0] max_length_ff, max_length_in;

   // Result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [REASON_W-1:0] rsp_reason_ff, rsp_reason_in;

   name_state_type      step_state;
   logic [REASON_W-1:0] step_reason;
   logic                out_free;
   logic                in_move;
   logic                req_xfer;

   tnuv_name_check u_check (
      .cur_state   (state_ff),
      .byte_in     (in_byte_ff),
      .no_byte     (in_none_ff),
      .max_length  (max_length_ff),
      .nxt_state   (step_state),
      .fail_reason (step_reason)
   );

   // Handshake: a held item moves unless it ends a name and the result slot is busy
   always_comb begin
      out_free   = !rsp_valid_ff || rsp_tready;
      in_move    = in_valid_ff && (!in_last_ff || out_free);
      req_tready = !in_valid_ff || in_move;
      req_xfer   = req_tvalid && req_tready;
      csr_ready  = 1'b1;
   end

   // Next values
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      in_none_in  = in_none_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
         in_last_in  = req_tlast;
         in_none_in  = req_tuser;
      end else if (in_move) begin
         in_valid_in = 1'b0;
      end

      state_in = state_ff;
      if (in_move) begin
         state_in = in_last_ff ? NAME_STATE_CLEAR : step_state;
      end

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_reason_in = rsp_reason_ff;
      if (in_move && in_last_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_reason_in = step_reason;
      end

      max_length_in = max_length_ff;
      if (csr_valid && csr_ready) begin
         max_length_in = csr_data;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= NAME_STATE_CLEAR;
         max_length_ff <= MAX_LENGTH_RESET;
      end else begin
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         state_ff      <= state_in;
         max_length_ff <= max_length_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_byte_ff    <= in_byte_in;
      in_last_ff    <= in_last_in;
      in_none_ff    <= in_none_in;
      rsp_reason_ff <= rsp_reason_in;
   end

   // Verdict output
   always_comb begin
      rsp_tvalid = rsp_valid_ff;
      rsp_tdata  = {4'b0000, rsp_reason_ff, (rsp_reason_ff == REASON_OK)};
   end

endmodule

`default_nettype wire
